// ----- src/spq_pkg.sv -----
// Shared constants and types for the sorted minimum priority queue.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 16;
    localparam int HIST_W   = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_PEEK   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [POS_W-1:0]    position;
        logic [HIST_W-1:0]   history;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- src/sorted_min_priority_queue_core.sv -----
// Top level of the sorted minimum priority queue built from a chain of cells.
//
// Usage:
//   Drive i_func, i_key, i_position and i_history and raise i_start. A command
//   transfers at a rising edge where i_start is high and o_busy is low; o_busy
//   stays low, so one command may transfer in every cycle.
//   Commands: insert, pop minimum, peek minimum, clear all.
//   Every command gives one result, shown on the o_ ports for one cycle with
//   o_done high, in the cycle after the command transfers.
//   Throughput: one command per cycle. Each cell compares its key with the
//   new key and moves one place left or right in the same cycle, so the
//   sorted row is updated in a single step for insert and pop.
//   o_occupancy gives the entry count after the command. Pop or peek on an
//   empty queue sets o_was_empty; insert into a full queue sets o_overflow
//   and is dropped. Payload outputs are zero except for a pop or peek hit.
//   Reset empties the queue and clears o_done; stored entries are not
//   cleared. The receiver cannot stall: each result is taken in its cycle.
module sorted_min_priority_queue_core
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_key,
    input  logic [15:0] i_position,
    input  logic [31:0] i_history,
    output logic        o_done,
    output logic [31:0] o_out_key,
    output logic [15:0] o_out_position,
    output logic [31:0] o_out_history,
    output logic        o_was_empty,
    output logic        o_overflow,
    output logic [4:0]  o_occupancy
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_entry           r_out;
    t_entry           n_out;
    logic             r_was_empty;
    logic             n_was_empty;
    logic             r_overflow;
    logic             n_overflow;

    t_entry           w_new;
    t_cell_ctl        w_ctl;
    t_entry           w_entry [CAPACITY];
    logic             w_ins   [CAPACITY];
    logic             w_full;
    logic             w_empty;

    assign o_busy  = 1'b0;
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    assign w_new.key      = KEY_BITS'(i_key);
    assign w_new.position = i_position;
    assign w_new.history  = i_history;

    assign w_ctl.insert = i_start && (i_func == FUNC_INSERT) && !w_full;
    assign w_ctl.pop    = i_start && (i_func == FUNC_POP) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left;
            logic   w_left_ins;
            t_entry w_right;
            logic   w_valid;

            if (g == 0) begin : g_head
                assign w_left     = w_new;
                assign w_left_ins = 1'b0;
            end else begin : g_mid
                assign w_left     = w_entry[g-1];
                assign w_left_ins = w_ins[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = w_entry[g];
            end else begin : g_body
                assign w_right = w_entry[g+1];
            end

            assign w_valid = (CNT_W'(g) < r_count);

            spq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_valid    (w_valid),
                .i_new      (w_new),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_out       = '0;
        n_was_empty = 1'b0;
        n_overflow  = 1'b0;
        case (i_func)
            FUNC_INSERT: begin
                if (w_full) begin
                    n_overflow = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (w_empty) begin
                    n_was_empty = 1'b1;
                end else begin
                    n_out = w_entry[0];
                    if (i_func == FUNC_POP) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_out       <= n_out;
            r_was_empty <= n_was_empty;
            r_overflow  <= n_overflow;
        end
    end

    assign o_done         = r_done;
    assign o_out_key      = 32'(r_out.key);
    assign o_out_position = r_out.position;
    assign o_out_history  = r_out.history;
    assign o_was_empty    = r_was_empty;
    assign o_overflow     = r_overflow;
    assign o_occupancy    = 5'(r_count);

endmodule

// ----- src/spq_cell.sv -----
// One storage cell of the sorted shift array.
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_ins,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_ins
);

    t_entry r_entry;
    t_entry n_entry;

    // insertion point is at or before this cell
    assign o_ins   = !i_valid || (r_entry.key >= i_new.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (i_left_ins) begin
                n_entry = i_left;
            end else if (o_ins) begin
                n_entry = i_new;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
